/* src/byte_stack_with_rotate_unit_macros.svh */
`ifndef BYTE_STACK_WITH_ROTATE_UNIT_MACROS_SVH
`define BYTE_STACK_WITH_ROTATE_UNIT_MACROS_SVH

// The macros expect the signal aclk, and BSR_ASSERT_NOW also aresetn, in the scope where they are used.

// Same-cycle implication, disabled while reset is asserted.
`define BSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, active during reset as well.
`define BSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bsr_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam logic [5:0] CAP_RESET = 6'd32;

    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_PEEK   = 3'd2;
    localparam logic [2:0] REQ_DUP    = 3'd3;
    localparam logic [2:0] REQ_ROT_UP = 3'd4;
    localparam logic [2:0] REQ_ROT_DN = 3'd5;
    localparam logic [2:0] REQ_PRINT  = 3'd6;

    localparam logic [2:0] KIND_PEEK  = 3'd0;
    localparam logic [2:0] KIND_EMPTY = 3'd1;
    localparam logic [2:0] KIND_FULL  = 3'd2;
    localparam logic [2:0] KIND_ENTRY = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PRINT_RD,
        ST_PRINT_OUT,
        ST_PRINT_END
    } state_t;

    typedef struct packed {
        logic       latch;
        logic       push;
        logic       pop;
        logic       dup;
        logic       rot_up;
        logic       rot_dn;
        logic       print_load;
        logic       print_read;
        logic       print_step;
        logic       emit;
        logic [2:0] kind;
        logic       use_rd;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       full;
        logic       empty;
        logic       rank_ok;
        logic       ptr_zero;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

/* src/byte_stack_with_rotate_unit.sv */
// Channel   Direction  tdata (low bit up)               tuser             tlast
// s_        in         data_byte[7:0], rank[13:8]       req_type[2:0]     -
// m_        out        result_byte[7:0]                 result_kind[2:0]  last
// cfg_      in         cfg_wr_data = capacity[5:0]      -                 -
//
// An item is taken only when the controller is idle; push, pop, dup and rotates are
// accepted, then executed with all affected entries shifted at once.
// Peek and error items are accepted, then executed once the output register is free.
// Print is accepted, then each entry is read from the register file and then output,
// and a last check of the pointer is followed by the end marker.
// Reset clears the fill count and sets capacity to 32; the entries themselves are not cleared.
// While m_tready is low the result register holds and the controller waits on its next one.
`timescale 1ns / 1ps
`default_nettype none
module byte_stack_with_rotate_unit #(
    parameter int DEPTH = bsr_pkg::DEPTH_DEFAULT
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [15:0] s_tdata,   // data_byte[7:0], rank[13:8], zero pad
    input  wire [2:0]  s_tuser,   // req_type[2:0]
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // result_byte[7:0]
    output logic [2:0] m_tuser,   // result_kind[2:0]
    output logic       m_tlast,
    input  wire        cfg_wr_en,
    input  wire [5:0]  cfg_wr_data
);
    import bsr_pkg::*;

    cmd_t    cmd;
    status_t status;

    bsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bsr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

/* src/bsr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module bsr_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  bsr_pkg::status_t status,
    output bsr_pkg::cmd_t    cmd
);
    import bsr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.req)
                    REQ_PUSH, REQ_DUP: begin
                        if (!status.full || status.out_free) begin
                            state_next = ST_IDLE;
                        end
                    end
                    REQ_POP, REQ_PEEK: begin
                        if (status.out_free) begin
                            state_next = ST_IDLE;
                        end else if (status.req == REQ_POP && !status.empty) begin
                            state_next = ST_IDLE;
                        end
                    end
                    REQ_PRINT: state_next = ST_PRINT_RD;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_PRINT_RD: begin
                state_next = status.ptr_zero ? ST_PRINT_END : ST_PRINT_OUT;
            end
            ST_PRINT_OUT: begin
                if (status.out_free) begin
                    state_next = ST_PRINT_RD;
                end
            end
            ST_PRINT_END: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                cmd.latch = s_tvalid;
            end
            ST_EXEC: begin
                case (status.req)
                    REQ_PUSH, REQ_DUP: begin
                        if (status.full) begin
                            cmd.emit = status.out_free;
                            cmd.kind = KIND_FULL;
                            cmd.last = 1'b1;
                        end else if (status.req == REQ_PUSH) begin
                            cmd.push = 1'b1;
                        end else begin
                            // Dup of an empty stack does nothing.
                            cmd.dup = !status.empty;
                        end
                    end
                    REQ_POP: begin
                        if (status.empty) begin
                            cmd.emit = status.out_free;
                            cmd.kind = KIND_EMPTY;
                            cmd.last = 1'b1;
                        end else begin
                            cmd.pop = 1'b1;
                        end
                    end
                    REQ_PEEK: begin
                        cmd.emit   = status.out_free;
                        cmd.kind   = status.empty ? KIND_EMPTY : KIND_PEEK;
                        cmd.use_rd = !status.empty;
                        cmd.last   = 1'b1;
                    end
                    REQ_ROT_UP: cmd.rot_up = status.rank_ok;
                    REQ_ROT_DN: cmd.rot_dn = status.rank_ok;
                    REQ_PRINT:  cmd.print_load = 1'b1;
                    default: ;
                endcase
            end
            ST_PRINT_RD: begin
                cmd.print_read = !status.ptr_zero;
            end
            ST_PRINT_OUT: begin
                cmd.emit       = status.out_free;
                cmd.print_step = status.out_free;
                cmd.kind       = KIND_ENTRY;
                cmd.use_rd     = 1'b1;
            end
            ST_PRINT_END: begin
                cmd.emit = status.out_free;
                cmd.kind = KIND_END;
                cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* src/bsr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module bsr_datapath #(
    parameter int DEPTH = bsr_pkg::DEPTH_DEFAULT
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire  [15:0]      s_tdata,
    input  wire  [2:0]       s_tuser,
    input  wire              cfg_wr_en,
    input  wire  [5:0]       cfg_wr_data,
    input  bsr_pkg::cmd_t    cmd,
    output bsr_pkg::status_t status,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [7:0]       m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);
    import bsr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > 6) ? FW : 6;

    logic [7:0]    stack_reg [DEPTH];
    logic [7:0]    stack_next [DEPTH];
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] ptr_reg, ptr_next;
    logic [5:0]    cap_reg;
    logic [2:0]    req_reg;
    logic [7:0]    data_reg;
    logic          rank_ok_reg;
    logic [AW-1:0] top_reg, bot_reg;
    logic [7:0]    rd_data_reg;
    logic          m_valid_reg;
    logic [2:0]    m_kind_reg;
    logic [7:0]    m_byte_reg;
    logic          m_last_reg;

    logic [CW-1:0] fill_ext, rank_ext, cap_eff;
    logic [CW-1:0] top_full, bot_full, ptr_full;
    logic [AW-1:0] rd_addr;
    logic          in_rank_ok;

    always_comb begin
        fill_ext   = CW'(fill_reg);
        rank_ext   = CW'(s_tdata[13:8]);
        cap_eff    = (CW'(cap_reg) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_reg);
        top_full   = fill_ext - CW'(1);
        bot_full   = fill_ext - rank_ext;
        ptr_full   = CW'(ptr_reg) - CW'(1);
        in_rank_ok = (rank_ext != '0) && (rank_ext <= fill_ext);
        // One read port: top or rotate bottom when an item arrives, else the print pointer.
        if (cmd.latch) begin
            rd_addr = (s_tuser == REQ_ROT_DN) ? bot_full[AW-1:0] : top_full[AW-1:0];
        end else begin
            rd_addr = ptr_full[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch || cmd.print_read) begin
            if ({1'b0, rd_addr} < (AW+1)'(DEPTH)) begin
                rd_data_reg <= stack_reg[rd_addr];
            end else begin
                rd_data_reg <= '0;
            end
        end
        if (cmd.latch) begin
            req_reg     <= s_tuser;
            data_reg    <= s_tdata[7:0];
            rank_ok_reg <= in_rank_ok;
            top_reg     <= top_full[AW-1:0];
            bot_reg     <= bot_full[AW-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            stack_next[i] = stack_reg[i];
            if ((cmd.push || cmd.dup) && fill_reg == FW'(i)) begin
                stack_next[i] = cmd.push ? data_reg : rd_data_reg;
            end
            if (cmd.rot_up) begin
                if (AW'(i) == bot_reg) begin
                    stack_next[i] = rd_data_reg;
                end else if (AW'(i) > bot_reg && AW'(i) <= top_reg) begin
                    if (i > 0) begin
                        stack_next[i] = stack_reg[i-1];
                    end
                end
            end
            if (cmd.rot_dn) begin
                if (AW'(i) == top_reg) begin
                    stack_next[i] = rd_data_reg;
                end else if (AW'(i) >= bot_reg && AW'(i) < top_reg) begin
                    if (i < DEPTH - 1) begin
                        stack_next[i] = stack_reg[i+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            stack_reg[i] <= stack_next[i];
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.push || cmd.dup) begin
            fill_next = fill_reg + FW'(1);
        end else if (cmd.pop) begin
            fill_next = fill_reg - FW'(1);
        end
        ptr_next = ptr_reg;
        if (cmd.print_load) begin
            ptr_next = fill_reg;
        end else if (cmd.print_step) begin
            ptr_next = ptr_reg - FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            ptr_reg     <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_kind_reg <= cmd.kind;
            m_byte_reg <= cmd.use_rd ? rd_data_reg : 8'd0;
            m_last_reg <= cmd.last;
        end
    end

    always_comb begin
        status.req      = req_reg;
        status.full     = (fill_ext >= cap_eff);
        status.empty    = (fill_reg == '0);
        status.rank_ok  = rank_ok_reg;
        status.ptr_zero = (ptr_reg == '0);
        status.out_free = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

/* src/bsr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stack_with_rotate_unit_macros.svh"
module bsr_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_tvalid,
    input wire       s_tready,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire [2:0] m_tuser,
    input wire       m_tlast
);
    import bsr_pkg::*;

    // A stalled result must hold.
    `BSR_ASSERT_NEXT(a_hold, aresetn && m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // Only print entries can be followed by further results of the same item.
    `BSR_ASSERT_NOW(a_notlast_entry, m_tvalid && !m_tlast, m_tuser == KIND_ENTRY, "non-final result is not a print entry")

    // Errors and the print end carry a zero byte.
    `BSR_ASSERT_NOW(a_zero_byte, m_tvalid && m_tuser != KIND_PEEK && m_tuser != KIND_ENTRY, m_tdata == 8'd0, "error or end result has nonzero byte")

    // No new item is taken while a print entry is on the output.
    `BSR_ASSERT_NOW(a_busy_print, m_tvalid && !m_tlast, !(s_tvalid && s_tready), "input accepted during print")

    // Reset empties the output register.
    `BSR_ASSERT_NEXT(a_reset, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind byte_stack_with_rotate_unit bsr_checker u_bsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
